// ===== hw/rtl/hgp_pkg.sv =====
// shared types, constants and byte-class helpers for the http get request parser
`default_nettype none

package hgp_pkg;

  // request size limit and derived widths
  localparam int unsigned MAX_REQUEST_BYTES = 4096;
  localparam int POS_W  = $clog2(MAX_REQUEST_BYTES + 1);
  localparam int OFS_W  = 12;
  localparam int HIST_W = 56;

  // parser phases
  localparam logic [3:0] PH_START       = 4'd0;
  localparam logic [3:0] PH_METHOD      = 4'd1;
  localparam logic [3:0] PH_BEFORE_URI  = 4'd2;
  localparam logic [3:0] PH_URI         = 4'd3;
  localparam logic [3:0] PH_BEFORE_HTTP = 4'd4;
  localparam logic [3:0] PH_HTTP        = 4'd5;
  localparam logic [3:0] PH_NAME        = 4'd6;
  localparam logic [3:0] PH_SEPARATOR   = 4'd7;
  localparam logic [3:0] PH_CRLF        = 4'd8;
  localparam logic [3:0] PH_LWS         = 4'd9;
  localparam logic [3:0] PH_VALUE       = 4'd10;

  // event codes
  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_URI         = 3'd1;
  localparam logic [2:0] EV_HEADER      = 3'd2;
  localparam logic [2:0] EV_HEADER_DONE = 3'd3;
  localparam logic [2:0] EV_DONE        = 3'd4;
  localparam logic [2:0] EV_BAD_METHOD  = 3'd5;
  localparam logic [2:0] EV_BAD_REQUEST = 3'd6;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [23:0] WORD_GET    = 24'h474554;
  localparam logic [63:0] WORD_HTTP11 = 64'h485454502F312E31;

  // parser state
  typedef struct packed {
    logic [3:0]        phase;
    logic              finished;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  mark;
    logic [POS_W-1:0]  name_start;
    logic [POS_W-1:0]  name_len;
    logic [POS_W-1:0]  trail_cnt;
    logic              after_nl;
    logic [HIST_W-1:0] recent;
  } state_t;

  // one result beat
  typedef struct packed {
    logic [7:0]       out_byte;
    logic [2:0]       event_res;
    logic [OFS_W-1:0] span_start;
    logic [OFS_W-1:0] span_length;
    logic [OFS_W-1:0] name_start;
    logic [OFS_W-1:0] name_length;
  } result_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    logic [7:0] l;
    l = c | CASE_BIT;
    return (l >= 8'h61) && (l <= 8'h7A);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - CASE_BIT) : c;
  endfunction

  function automatic logic is_http_char(input logic [7:0] c);
    return (c == CH_H) || (c == CH_T) || (c == CH_P) || (c == CH_SLASH) ||
           (c == CH_ONE) || (c == CH_DOT);
  endfunction

  function automatic logic is_name_sep(input logic [7:0] c);
    logic r;
    case (c) inside
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h5C, 8'h22, 8'h2F,
      8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h0D, 8'h0A, 8'h20,
      8'h09: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hgp_core.sv =====
// parser state registers and the one-byte step logic
`default_nettype none

module hgp_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,      // commit this byte
  input  wire logic [7:0]      in_byte,
  input  wire logic            restart,
  output hgp_pkg::result_t     result
);

  hgp_pkg::state_t st;
  hgp_pkg::state_t st_next;
  hgp_pkg::state_t cur;

  logic [7:0]               ch;
  logic [hgp_pkg::POS_W-1:0] p;
  logic [hgp_pkg::POS_W-1:0] diff;
  logic [hgp_pkg::POS_W-1:0] end_pos;
  logic [hgp_pkg::POS_W-1:0] val_len;
  logic [7:0]               ob;
  logic [2:0]               ev;
  logic [hgp_pkg::POS_W-1:0] s_start;
  logic [hgp_pkg::POS_W-1:0] s_len;
  logic [hgp_pkg::POS_W-1:0] n_start;
  logic [hgp_pkg::POS_W-1:0] n_len;

  // restart clears the state before the byte is taken
  assign cur     = restart ? '0 : st;
  assign ch      = in_byte;
  assign p       = cur.position;
  assign diff    = p - cur.mark;
  assign end_pos = p - cur.trail_cnt;
  assign val_len = (end_pos > cur.mark) ? (end_pos - cur.mark) : '0;

  // step logic
  always_comb begin
    st_next = cur;
    ob      = ch;
    ev      = hgp_pkg::EV_NONE;
    s_start = '0;
    s_len   = '0;
    n_start = '0;
    n_len   = '0;
    if (!cur.finished && (p >= hgp_pkg::POS_W'(hgp_pkg::MAX_REQUEST_BYTES))) begin
      ev = hgp_pkg::EV_BAD_REQUEST;
    end else if (!cur.finished) begin
      unique case (cur.phase)
        hgp_pkg::PH_START: begin
          st_next.mark = p;
          if ((ch == hgp_pkg::CH_LF) || (ch == hgp_pkg::CH_CR) || (ch == hgp_pkg::CH_NUL)) begin
          end else if (!hgp_pkg::is_upper(ch)) begin
            ev = hgp_pkg::EV_BAD_METHOD;
          end else begin
            st_next.phase = hgp_pkg::PH_METHOD;
          end
        end
        hgp_pkg::PH_METHOD: begin
          if (ch == hgp_pkg::CH_SP) begin
            if ((diff == hgp_pkg::POS_W'(3)) && (cur.recent[23:0] == hgp_pkg::WORD_GET))
              st_next.phase = hgp_pkg::PH_BEFORE_URI;
            else
              ev = hgp_pkg::EV_BAD_METHOD;
          end else if (!hgp_pkg::is_upper(ch)) begin
            ev = hgp_pkg::EV_BAD_METHOD;
          end
        end
        hgp_pkg::PH_BEFORE_URI: begin
          if (ch == hgp_pkg::CH_SLASH) begin
            st_next.mark  = p;
            st_next.phase = hgp_pkg::PH_URI;
          end else if (!hgp_pkg::is_alpha(ch) && (ch != hgp_pkg::CH_SP)) begin
            ev = hgp_pkg::EV_BAD_REQUEST;
          end
        end
        hgp_pkg::PH_URI: begin
          if (ch == hgp_pkg::CH_SP) begin
            ev            = hgp_pkg::EV_URI;
            s_start       = cur.mark;
            s_len         = diff;
            st_next.phase = hgp_pkg::PH_BEFORE_HTTP;
          end else if ((ch == hgp_pkg::CH_LF) || (ch == hgp_pkg::CH_CR) ||
                       (ch == hgp_pkg::CH_NUL)) begin
            ev = hgp_pkg::EV_BAD_REQUEST;
          end
        end
        hgp_pkg::PH_BEFORE_HTTP: begin
          if (ch == hgp_pkg::CH_H) begin
            st_next.mark  = p;
            st_next.phase = hgp_pkg::PH_HTTP;
          end else if (ch != hgp_pkg::CH_SP) begin
            ev = hgp_pkg::EV_BAD_REQUEST;
          end
        end
        hgp_pkg::PH_HTTP: begin
          if (hgp_pkg::is_http_char(ch)) begin
            if ((diff == hgp_pkg::POS_W'(7)) && ({cur.recent, ch} == hgp_pkg::WORD_HTTP11))
              st_next.phase = hgp_pkg::PH_CRLF;
            else if (diff > hgp_pkg::POS_W'(7))
              ev = hgp_pkg::EV_BAD_REQUEST;
          end else begin
            ev = hgp_pkg::EV_BAD_REQUEST;
          end
        end
        hgp_pkg::PH_CRLF: begin
          st_next.trail_cnt = '0;
          if ((ch == hgp_pkg::CH_CR) || (ch == hgp_pkg::CH_LF)) begin
          end else if ((ch == hgp_pkg::CH_SP) || (ch == hgp_pkg::CH_TAB)) begin
            st_next.phase = hgp_pkg::PH_LWS;
          end else begin
            st_next.mark  = p;
            ob            = hgp_pkg::to_upper(ch);
            st_next.phase = hgp_pkg::PH_NAME;
          end
        end
        hgp_pkg::PH_LWS: begin
          st_next.trail_cnt = '0;
          if (ch == hgp_pkg::CH_CR) begin
          end else if (ch == hgp_pkg::CH_LF) begin
            if (cur.after_nl) ev = hgp_pkg::EV_DONE;
            else st_next.after_nl = 1'b1;
          end else begin
            st_next.after_nl = 1'b0;
            if ((ch == hgp_pkg::CH_SP) || (ch == hgp_pkg::CH_TAB)) begin
              st_next.phase = hgp_pkg::PH_VALUE;
            end else begin
              st_next.mark  = p;
              ob            = hgp_pkg::to_upper(ch);
              st_next.phase = hgp_pkg::PH_NAME;
            end
          end
        end
        hgp_pkg::PH_NAME: begin
          if (hgp_pkg::is_name_sep(ch)) begin
            ev = hgp_pkg::EV_BAD_REQUEST;
          end else if (ch == hgp_pkg::CH_COLON) begin
            st_next.name_start = cur.mark;
            st_next.name_len   = diff;
            st_next.phase      = hgp_pkg::PH_SEPARATOR;
          end else begin
            ob = hgp_pkg::to_upper(ch);
          end
        end
        hgp_pkg::PH_SEPARATOR: begin
          if ((ch == hgp_pkg::CH_SP) || (ch == hgp_pkg::CH_TAB) || (ch == hgp_pkg::CH_CR)) begin
          end else if (ch == hgp_pkg::CH_LF) begin
            st_next.after_nl = 1'b1;
            st_next.phase    = hgp_pkg::PH_LWS;
          end else begin
            st_next.mark  = p;
            st_next.phase = hgp_pkg::PH_VALUE;
          end
        end
        hgp_pkg::PH_VALUE: begin
          if (ch == hgp_pkg::CH_CR) begin
            st_next.trail_cnt = cur.trail_cnt + 1'b1;
          end else if (ch == hgp_pkg::CH_LF) begin
            if (cur.after_nl) begin
              ev                = hgp_pkg::EV_HEADER_DONE;
              s_start           = cur.mark;
              s_len             = val_len;
              n_start           = cur.name_start;
              n_len             = cur.name_len;
              st_next.trail_cnt = '0;
            end else begin
              st_next.after_nl  = 1'b1;
              st_next.trail_cnt = cur.trail_cnt + 1'b1;
            end
          end else if ((ch == hgp_pkg::CH_SP) || (ch == hgp_pkg::CH_TAB)) begin
            if (cur.after_nl) begin
              st_next.after_nl  = 1'b0;
              st_next.trail_cnt = '0;
            end
          end else if (cur.after_nl) begin
            // a new header name closes the previous value
            st_next.after_nl  = 1'b0;
            ev                = hgp_pkg::EV_HEADER;
            s_start           = cur.mark;
            s_len             = val_len;
            n_start           = cur.name_start;
            n_len             = cur.name_len;
            st_next.trail_cnt = '0;
            st_next.mark      = p;
            ob                = hgp_pkg::to_upper(ch);
            st_next.phase     = hgp_pkg::PH_NAME;
          end
        end
        default: begin
        end
      endcase
      if (ev >= hgp_pkg::EV_HEADER_DONE) st_next.finished = 1'b1;
      st_next.recent   = {cur.recent[hgp_pkg::HIST_W-9:0], ch};
      st_next.position = p + 1'b1;
    end
    if (ev == hgp_pkg::EV_BAD_REQUEST) st_next.finished = 1'b1;
  end

  // result fields, offsets trimmed to the port width
  always_comb begin
    result.out_byte    = ob;
    result.event_res   = ev;
    result.span_start  = hgp_pkg::OFS_W'(s_start);
    result.span_length = hgp_pkg::OFS_W'(s_len);
    result.name_start  = hgp_pkg::OFS_W'(n_start);
    result.name_length = hgp_pkg::OFS_W'(n_len);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // a terminal event leaves the parser finished
  a_terminal_sticks: assert property (@(posedge clk) disable iff (rst)
    fire && ((ev == hgp_pkg::EV_HEADER_DONE) || (ev == hgp_pkg::EV_DONE) ||
             (ev == hgp_pkg::EV_BAD_METHOD) || (ev == hgp_pkg::EV_BAD_REQUEST))
    |=> st.finished)
    else $error("terminal event did not finish the request");

  // a finished request only echoes until restart
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    st.finished && !restart |-> (ev == hgp_pkg::EV_NONE) && (st_next == st))
    else $error("finished parser produced an event or changed state");

  // offset counter never runs past the request limit
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    st.position <= hgp_pkg::POS_W'(hgp_pkg::MAX_REQUEST_BYTES))
    else $error("position beyond request limit");

  // state moves only when a byte is committed
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(st))
    else $error("parser state changed without a byte");

endmodule

`default_nettype wire

// ===== hw/rtl/http_get_request_parser_top.sv =====
// top level: input beat register, parser core and result beat register
//
//  channel  | dir | tdata                                       | tuser
//  s_axis   | in  | in_byte[7:0]                                | restart[0]
//  m_axis   | out | out_byte, span_start, span_length,          | event_res[2:0]
//           |     | name_start, name_length (8+12+12+12+12)     |
//
// one beat in, one beat out, sustained at one beat per cycle while m_axis does not stall
// a beat passes through the input register, then the parser step into the result register
// parser state commits as a beat moves from the input register to the result register
// rst clears both valid flags and the parser state; restart in tuser clears it per request
// a stall on m_axis holds the result; the input register holds at most one more beat before s_axis stalls
`default_nettype none

module http_get_request_parser_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // in_byte
  input  wire logic [0:0]  s_axis_tuser,   // restart
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // out_byte, span_start, span_length,
                                           // name_start, name_length
  output logic [2:0]       m_axis_tuser    // event_res
);

  logic              in_valid;
  logic [7:0]        in_byte_q;
  logic              restart_q;
  logic              advance;
  hgp_pkg::result_t  step_res;
  hgp_pkg::result_t  out_res;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // input beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      restart_q <= s_axis_tuser[0];
    end
  end

  hgp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .in_byte (in_byte_q),
    .restart (restart_q),
    .result  (step_res)
  );

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tdata = {out_res.name_length, out_res.name_start, out_res.span_length,
                         out_res.span_start, out_res.out_byte};
  assign m_axis_tuser = out_res.event_res;

endmodule

`default_nettype wire
